// ===== rtl/core/gcab_pkg.sv =====
// gcab_pkg: shared widths, register indexes, reset values and types of the alpha-blend renderer
package gcab_pkg;

    // default sizes of the colour table and of the column range
    localparam int GCAB_TABLE_DEPTH = 1024;
    localparam int GCAB_MAX_COLUMNS = 1024;

    // field widths
    localparam int COL_W      = 10;
    localparam int LEVEL_W    = 8;
    localparam int MASK_W     = 10;
    localparam int GW_W       = 11;
    localparam int COLOR_W    = 32;
    localparam int CH_W       = 8;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 24;

    // rgba channels, red first
    localparam int NUM_CH    = 4;
    localparam int NUM_RGB   = 3;
    localparam int ALPHA_CH  = 3;
    // divider lanes: table step plus one slope per channel
    localparam int NUM_LANES = NUM_CH + 1;
    // signed 9.16 slope, magnitude below 2^24
    localparam int DC_W      = CH_W + FRAC_W + 1;
    localparam int GPROD_W   = COL_W + 1 + DC_W;
    // signed blend product (diff * alpha)
    localparam int FC_W      = 2 * (CH_W + 1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_COLOR    = 3'd0,
        CFG_END_COLOR      = 3'd1,
        CFG_DARK_LEVEL     = 3'd2,
        CFG_LIGHT_LEVEL    = 3'd3,
        CFG_CHECK_MASK     = 3'd4,
        CFG_GRADIENT_WIDTH = 3'd5,
        CFG_USE_MAP        = 3'd6
    } cfg_reg_t;

    // register reset values
    localparam logic [COLOR_W-1:0] START_COLOR_RST    = 32'h0000_00ff;
    localparam logic [COLOR_W-1:0] END_COLOR_RST      = 32'hffff_ffff;
    localparam logic [LEVEL_W-1:0] DARK_LEVEL_RST     = 8'h5f;
    localparam logic [LEVEL_W-1:0] LIGHT_LEVEL_RST    = 8'ha0;
    localparam logic [MASK_W-1:0]  CHECK_MASK_RST     = 10'h008;
    localparam logic [GW_W-1:0]    GRADIENT_WIDTH_RST = 11'd96;

    // blend rounding offset
    localparam int ROUND_HALF = 'h80;

    // slope / step divider sequencer
    typedef enum logic [1:0] {
        DIV_LOAD,
        DIV_RUN,
        DIV_STORE,
        DIV_IDLE
    } div_state_t;

    // channel k of a packed rgba word, k = 0 is red in the top byte
    function automatic logic [CH_W-1:0] rgba_chan(input logic [COLOR_W-1:0] c, input int k);
        return c[COLOR_W - CH_W * (k + 1) +: CH_W];
    endfunction

endpackage

// ===== rtl/core/gradient_checker_alpha_blend.sv =====
// gradient_checker_alpha_blend: per-pixel gradient or table colour blended over a checkerboard
//
//  channel   dir  handshake                 payload (lowest bit first)
//  s_        in   s_tvalid / s_tready       tuser: action; tdata: column, row, table_index,
//                                            table_entry
//  m_        out  m_tvalid / m_tready       tdata: red, green, blue
//  cfg_      in   cfg_wr_en (no wait)       cfg_index, cfg_wr_data
//
//  one transfer per clock while s_tready is high; the valid bit passes v1, v2, v3, v4 and out_v to m_tvalid
//  the pipeline: accept, multiply, table access, blend multiply, round into the output register
//  table writes and table reads share one memory port at the table access stage, in order
//  after reset and after every register write, s_tready stays low through the load, run and store states
//  while the shared divider works out the table step and the four channel slopes
//  stages hold while the output is stalled; empty stages close up, so input keeps flowing
module gradient_checker_alpha_blend
    import gcab_pkg::*;
#(
    parameter int TABLE_DEPTH = GCAB_TABLE_DEPTH,
    parameter int MAX_COLUMNS = GCAB_MAX_COLUMNS
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,     // column, row, table_index, table_entry
    input  logic                  s_tuser,     // action

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,     // red, green, blue

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    // table address width
    localparam int TIW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // effective gradient width, never above MAX_COLUMNS or the register range
    localparam int MC_W  = $clog2(MAX_COLUMNS + 1);
    localparam int W_W   = (MC_W < GW_W) ? MC_W : GW_W;
    // divider numerator: depth << 16 for the step, |c1 - c0| << 16 for a slope
    localparam int DEP_W = $clog2(TABLE_DEPTH + 1) + FRAC_W;
    localparam int NUM_W = (DEP_W > CH_W + FRAC_W) ? DEP_W : CH_W + FRAC_W;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int MP_W  = COL_W + NUM_W;
    localparam int IDX_W = MP_W - FRAC_W;
    localparam int GV_W  = GPROD_W + 1;
    localparam logic [NUM_W-1:0] STEP_NUM = NUM_W'(64'(TABLE_DEPTH) << FRAC_W);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] start_color_reg;
    logic [COLOR_W-1:0] end_color_reg;
    logic [LEVEL_W-1:0] dark_level_reg;
    logic [LEVEL_W-1:0] light_level_reg;
    logic [MASK_W-1:0]  check_mask_reg;
    logic [GW_W-1:0]    gradient_width_reg;
    logic               use_map_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_color_reg    <= START_COLOR_RST;
            end_color_reg      <= END_COLOR_RST;
            dark_level_reg     <= DARK_LEVEL_RST;
            light_level_reg    <= LIGHT_LEVEL_RST;
            check_mask_reg     <= CHECK_MASK_RST;
            gradient_width_reg <= GRADIENT_WIDTH_RST;
            use_map_reg        <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_START_COLOR:    start_color_reg    <= cfg_wr_data[COLOR_W-1:0];
                CFG_END_COLOR:      end_color_reg      <= cfg_wr_data[COLOR_W-1:0];
                CFG_DARK_LEVEL:     dark_level_reg     <= cfg_wr_data[LEVEL_W-1:0];
                CFG_LIGHT_LEVEL:    light_level_reg    <= cfg_wr_data[LEVEL_W-1:0];
                CFG_CHECK_MASK:     check_mask_reg     <= cfg_wr_data[MASK_W-1:0];
                CFG_GRADIENT_WIDTH: gradient_width_reg <= cfg_wr_data[GW_W-1:0];
                CFG_USE_MAP:        use_map_reg        <= cfg_wr_data[0];
                default: ;  // index past the register list: ignored
            endcase
        end
    end

    // width of zero counts as one, width past MAX_COLUMNS saturates
    logic [W_W-1:0] w_eff;
    always_comb begin
        if (gradient_width_reg == '0) begin
            w_eff = W_W'(1);
        end else if (32'(gradient_width_reg) > 32'(MAX_COLUMNS)) begin
            w_eff = W_W'(MAX_COLUMNS);
        end else begin
            w_eff = W_W'(gradient_width_reg);
        end
    end

    // ------------------------------------------------------------------
    // shared restoring divider: five lanes, one quotient bit per cycle
    // lane 0 gives the table step, lanes 1..4 the r, g, b, a slopes
    // ------------------------------------------------------------------
    div_state_t          div_state_reg, div_state_next;
    logic [CNT_W-1:0]    div_cnt_reg;
    logic [NUM_W-1:0]    quo_reg [NUM_LANES];
    logic [W_W:0]        rem_reg [NUM_LANES];
    logic                neg_reg [NUM_LANES];
    logic [NUM_W-1:0]    step_reg;
    logic signed [DC_W-1:0] dc_reg [NUM_CH];

    logic [NUM_W-1:0]    num_ld  [NUM_LANES];
    logic                neg_ld  [NUM_LANES];
    logic [NUM_W-1:0]    quo_nx  [NUM_LANES];
    logic [W_W:0]        rem_nx  [NUM_LANES];

    always_comb begin
        logic [CH_W:0] diff;
        logic [CH_W:0] mag;
        logic [W_W:0]  sh;
        for (int l = 0; l < NUM_LANES; l++) begin
            if (l == 0) begin
                diff      = '0;
                mag       = '0;
                num_ld[l] = STEP_NUM;
                neg_ld[l] = 1'b0;
            end else begin
                diff = {1'b0, rgba_chan(end_color_reg, l - 1)}
                     - {1'b0, rgba_chan(start_color_reg, l - 1)};
                mag  = diff[CH_W] ? (~diff + 1'b1) : diff;
                num_ld[l] = NUM_W'({mag[CH_W-1:0], {FRAC_W{1'b0}}});
                neg_ld[l] = diff[CH_W];
            end
            sh = {rem_reg[l][W_W-1:0], quo_reg[l][NUM_W-1]};
            if (sh >= {1'b0, w_eff}) begin
                rem_nx[l] = sh - {1'b0, w_eff};
                quo_nx[l] = {quo_reg[l][NUM_W-2:0], 1'b1};
            end else begin
                rem_nx[l] = sh;
                quo_nx[l] = {quo_reg[l][NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_state_reg <= DIV_LOAD;
        end else begin
            div_state_reg <= div_state_next;
        end
    end

    always_comb begin
        div_state_next = div_state_reg;
        if (cfg_wr_en) begin
            div_state_next = DIV_LOAD;
        end else begin
            unique case (div_state_reg)
                DIV_LOAD:  div_state_next = DIV_RUN;
                DIV_RUN: begin
                    if (div_cnt_reg == CNT_W'(NUM_W - 1)) begin
                        div_state_next = DIV_STORE;
                    end
                end
                DIV_STORE: div_state_next = DIV_IDLE;
                DIV_IDLE:  div_state_next = DIV_IDLE;
                default:   div_state_next = DIV_LOAD;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        logic [DC_W-1:0] mag_ext;
        unique case (div_state_reg)
            DIV_LOAD: begin
                div_cnt_reg <= '0;
                for (int l = 0; l < NUM_LANES; l++) begin
                    quo_reg[l] <= num_ld[l];
                    rem_reg[l] <= '0;
                    neg_reg[l] <= neg_ld[l];
                end
            end
            DIV_RUN: begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                for (int l = 0; l < NUM_LANES; l++) begin
                    quo_reg[l] <= quo_nx[l];
                    rem_reg[l] <= rem_nx[l];
                end
            end
            DIV_STORE: begin
                step_reg <= quo_reg[0];
                // magnitude quotient, sign put back: truncation toward zero
                for (int k = 0; k < NUM_CH; k++) begin
                    mag_ext   = {1'b0, quo_reg[k+1][DC_W-2:0]};
                    dc_reg[k] <= neg_reg[k+1] ? $signed(~mag_ext + 1'b1) : $signed(mag_ext);
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control: a stage loads when it is empty or the next one loads
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_v_reg;
    logic ld1, ld2, ld3, ld4, ld_out;
    logic s_fire;

    assign ld_out   = !out_v_reg || m_tready;
    assign ld4      = !v4_reg || ld_out;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign s_tready = ld1 && (div_state_reg == DIV_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (ld1)    v1_reg    <= s_fire;
            if (ld2)    v2_reg    <= v1_reg;
            // table writes end at the memory stage
            if (ld3)    v3_reg    <= v2_reg && !wr2_reg;
            if (ld4)    v4_reg    <= v3_reg;
            if (ld_out) out_v_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: unpack, clamp the column, pick the checker level
    // ------------------------------------------------------------------
    logic [COL_W-1:0]   col_in, row_in, tidx_in;
    logic [COLOR_W-1:0] tent_in;
    logic [COL_W-1:0]   x_in;
    logic [LEVEL_W-1:0] bg_in;

    assign col_in  = s_tdata[COL_W-1:0];
    assign row_in  = s_tdata[2*COL_W-1:COL_W];
    assign tidx_in = s_tdata[3*COL_W-1:2*COL_W];
    assign tent_in = s_tdata[3*COL_W +: COLOR_W];

    // colour taken at width-1 past the gradient; checker uses the raw column
    assign x_in  = (32'(col_in) < 32'(w_eff)) ? col_in : COL_W'(w_eff - 1'b1);
    assign bg_in = (|((col_in ^ row_in) & check_mask_reg)) ? dark_level_reg : light_level_reg;

    logic               wr1_reg;
    logic [COL_W-1:0]   x1_reg, tidx1_reg;
    logic [LEVEL_W-1:0] bg1_reg;
    logic [COLOR_W-1:0] tent1_reg;

    always_ff @(posedge aclk) begin
        if (ld1 && s_fire) begin
            wr1_reg   <= s_tuser;
            x1_reg    <= x_in;
            bg1_reg   <= bg_in;
            tidx1_reg <= tidx_in;
            tent1_reg <= tent_in;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: table index product and the four slope products
    // ------------------------------------------------------------------
    logic                      wr2_reg;
    logic [COL_W-1:0]          tidx2_reg;
    logic [LEVEL_W-1:0]        bg2_reg;
    logic [COLOR_W-1:0]        tent2_reg;
    logic [MP_W-1:0]           mprod2_reg;
    logic signed [GPROD_W-1:0] gprod2_reg [NUM_CH];

    always_ff @(posedge aclk) begin
        if (ld2 && v1_reg) begin
            wr2_reg    <= wr1_reg;
            tidx2_reg  <= tidx1_reg;
            bg2_reg    <= bg1_reg;
            tent2_reg  <= tent1_reg;
            mprod2_reg <= MP_W'(x1_reg) * MP_W'(step_reg);
            for (int k = 0; k < NUM_CH; k++) begin
                gprod2_reg[k] <= $signed({1'b0, x1_reg}) * dc_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: table write or read at one port; gradient channel bytes
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]   idx_full;
    logic [TIW-1:0]     map_addr, wr_addr;
    logic               wr_ok;
    logic [CH_W-1:0]    gbyte [NUM_CH];

    assign idx_full = mprod2_reg[MP_W-1:FRAC_W];
    assign map_addr = (64'(idx_full) > 64'(TABLE_DEPTH - 1)) ? TIW'(TABLE_DEPTH - 1)
                                                             : TIW'(idx_full);
    assign wr_ok    = 32'(tidx2_reg) < 32'(TABLE_DEPTH);
    assign wr_addr  = TIW'(tidx2_reg);

    always_comb begin
        logic signed [GV_W-1:0] gv;
        for (int k = 0; k < NUM_CH; k++) begin
            gv = $signed(GV_W'({rgba_chan(start_color_reg, k), {FRAC_W{1'b0}}}))
               + GV_W'(gprod2_reg[k]);
            gbyte[k] = gv[GV_W-1] ? '0 : gv[FRAC_W +: CH_W];
        end
    end

    logic [COLOR_W-1:0] color_mem [TABLE_DEPTH];
    logic [COLOR_W-1:0] rd_reg;

    // items reach this port in input order, so a read sees every earlier write
    always_ff @(posedge aclk) begin
        if (ld3 && v2_reg && wr2_reg && wr_ok) begin
            color_mem[wr_addr] <= tent2_reg;
        end
        if (ld3) begin
            rd_reg <= color_mem[map_addr];
        end
    end

    logic [CH_W-1:0]    g3_reg [NUM_CH];
    logic [LEVEL_W-1:0] bg3_reg;

    always_ff @(posedge aclk) begin
        if (ld3 && v2_reg) begin
            bg3_reg <= bg2_reg;
            for (int k = 0; k < NUM_CH; k++) begin
                g3_reg[k] <= gbyte[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 4: foreground select and (fg - bg) * alpha
    // ------------------------------------------------------------------
    logic [CH_W-1:0]        fg [NUM_CH];
    logic signed [FC_W-1:0] fc [NUM_RGB];

    always_comb begin
        logic [CH_W:0] d9;
        for (int k = 0; k < NUM_CH; k++) begin
            fg[k] = use_map_reg ? rgba_chan(rd_reg, k) : g3_reg[k];
        end
        for (int k = 0; k < NUM_RGB; k++) begin
            d9    = {1'b0, fg[k]} - {1'b0, bg3_reg};
            fc[k] = $signed(d9) * $signed({1'b0, fg[ALPHA_CH]});
        end
    end

    logic signed [FC_W-1:0] fc4_reg [NUM_RGB];
    logic [LEVEL_W-1:0]     bg4_reg;

    always_ff @(posedge aclk) begin
        if (ld4 && v3_reg) begin
            bg4_reg <= bg3_reg;
            for (int k = 0; k < NUM_RGB; k++) begin
                fc4_reg[k] <= fc[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // output: bg + floor((fc + floor(fc/256) + 0x80) / 256), low byte
    // ------------------------------------------------------------------
    logic [CH_W-1:0] pix_reg [NUM_RGB];

    always_ff @(posedge aclk) begin
        logic [FC_W:0] s;
        if (ld_out && v4_reg) begin
            for (int k = 0; k < NUM_RGB; k++) begin
                s = {fc4_reg[k][FC_W-1], fc4_reg[k]}
                  + {{(CH_W+1){fc4_reg[k][FC_W-1]}}, fc4_reg[k][FC_W-1:CH_W]}
                  + (FC_W+1)'(ROUND_HALF);
                pix_reg[k] <= bg4_reg + s[CH_W +: CH_W];
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {pix_reg[2], pix_reg[1], pix_reg[0]};

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // a register write stops input until the divider has redone its work
    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("input taken right after a register write");

    // a result only appears when stage 4 held one
    a_out_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) && !v4_reg |=> !m_tvalid)
        else $error("result with no item behind it");

    // renders pass the memory stage, table writes stop there
    a_render_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        ld3 && v2_reg && !wr2_reg |=> v3_reg)
        else $error("render lost at the table stage");

    a_write_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        ld3 && v2_reg && wr2_reg |=> !v3_reg)
        else $error("table write passed the table stage");

endmodule

// ===== tb/gcab_tb_pkg.sv =====
// gcab_tb_pkg: request codes and input word layout shared by the testbench files
`timescale 1ns / 1ps

package gcab_tb_pkg;

    typedef enum logic {
        ACT_RENDER      = 1'b0,
        ACT_TABLE_WRITE = 1'b1
    } action_t;

    // s_tdata layout, column in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [31:0] table_entry;
        logic [9:0]  table_index;
        logic [9:0]  row;
        logic [9:0]  column;
    } pixel_req_t;

endpackage

// ===== tb/pixel_checker.sv =====
// pixel_checker: predicts each blended pixel from the observed transfers and compares the output
`timescale 1ns / 1ps

module pixel_checker
    import gcab_pkg::*;
    import gcab_tb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output int                    mismatches,
    output int                    outstanding
);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    logic [31:0] start_rgba;
    logic [31:0] end_rgba;
    logic [7:0]  dark;
    logic [7:0]  light;
    logic [9:0]  mask;
    logic [10:0] width;
    logic        map_mode;
    logic [31:0] palette [GCAB_TABLE_DEPTH];
    pixel_t      pending_pixels [$];

    // one channel of the 16.16 ramp, k = 0 is red
    function automatic logic [7:0] ramp_level(input int k, input int col, input int span);
        longint c0, c1, slope, acc;
        c0 = start_rgba[31 - 8 * k -: 8];
        c1 = end_rgba[31 - 8 * k -: 8];
        slope = ((c1 - c0) * 65536) / span;
        acc = c0 * 65536 + col * slope;
        if (acc < 0)
            acc = 0;
        return acc[23:16];
    endfunction

    // signed blend with floor shifts and 257/256 rounding
    function automatic logic [7:0] blend_over(input logic [7:0] fg, input logic [7:0] bg,
                                              input logic [7:0] a);
        int fc, t;
        fc = (int'(fg) - int'(bg)) * int'(a);
        t = (fc + (fc >>> 8) + ROUND_HALF) >>> 8;
        return 8'(int'(bg) + t);
    endfunction

    function automatic pixel_t blended_pixel(input int col, input int row);
        int          span, x;
        longint      step, idx;
        logic [31:0] rgba;
        logic [7:0]  shade;
        pixel_t      p;
        span = width;
        if (span == 0)
            span = 1;
        if (span > GCAB_MAX_COLUMNS)
            span = GCAB_MAX_COLUMNS;
        x = (col < span) ? col : span - 1;
        if (map_mode) begin
            step = (longint'(GCAB_TABLE_DEPTH) << 16) / span;
            idx = (x * step) >> 16;
            if (idx >= GCAB_TABLE_DEPTH)
                idx = GCAB_TABLE_DEPTH - 1;
            rgba = palette[idx];
        end else begin
            for (int k = 0; k < 4; k++)
                rgba[31 - 8 * k -: 8] = ramp_level(k, x, span);
        end
        // checker square uses the raw column
        shade = (((col & mask) ^ (row & mask)) != 0) ? dark : light;
        p.red   = blend_over(rgba[31:24], shade, rgba[7:0]);
        p.green = blend_over(rgba[23:16], shade, rgba[7:0]);
        p.blue  = blend_over(rgba[15:8],  shade, rgba[7:0]);
        return p;
    endfunction

    task automatic check_channel(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %02h actual %02h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        pixel_req_t req;
        pixel_t     want, got;
        if (!aresetn) begin
            start_rgba = START_COLOR_RST;
            end_rgba   = END_COLOR_RST;
            dark       = DARK_LEVEL_RST;
            light      = LIGHT_LEVEL_RST;
            mask       = CHECK_MASK_RST;
            width      = GRADIENT_WIDTH_RST;
            map_mode   = 1'b0;
            pending_pixels.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    CFG_START_COLOR:    start_rgba = cfg_wr_data[31:0];
                    CFG_END_COLOR:      end_rgba = cfg_wr_data[31:0];
                    CFG_DARK_LEVEL:     dark = cfg_wr_data[7:0];
                    CFG_LIGHT_LEVEL:    light = cfg_wr_data[7:0];
                    CFG_CHECK_MASK:     mask = cfg_wr_data[9:0];
                    CFG_GRADIENT_WIDTH: width = cfg_wr_data[10:0];
                    CFG_USE_MAP:        map_mode = cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                req = s_tdata;
                if (s_tuser == ACT_TABLE_WRITE)
                    palette[req.table_index] = req.table_entry;
                else
                    pending_pixels.push_back(blended_pixel(req.column, req.row));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel, expected none actual %06h", $time, got);
                    mismatches++;
                end else begin
                    want = pending_pixels.pop_front();
                    check_channel("red", want.red, got.red);
                    check_channel("green", want.green, got.green);
                    check_channel("blue", want.blue, got.blue);
                end
            end
        end
        outstanding = pending_pixels.size();
    end

endmodule

// ===== tb/tb.sv =====
// tb: stimulus and verdict for the checkerboard alpha-blend renderer
`timescale 1ns / 1ps

module tb;
    import gcab_pkg::*;
    import gcab_tb_pkg::*;

    localparam int RESET_CYCLES  = 12;
    // leave room for table writes still in flight after the last pixel
    localparam int SETTLE_CYCLES = 10;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 68;
    localparam int FILL_ITEMS    = 64;
    localparam int NUM_REGS      = 7;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = ACT_RENDER;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int          mismatches;
    int          outstanding;
    logic [31:0] reg_value [NUM_REGS];
    bit          written [GCAB_TABLE_DEPTH];
    bit          sender_quiet = 1'b0;
    bit          receiver_quiet = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    gradient_checker_alpha_blend DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    pixel_checker CHECK (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // one input transfer; entered and left on a rising edge, s_tvalid stays high after it
    task automatic push_item(input action_t act, input int col, input int row,
                             input int tidx, input logic [31:0] entry);
        pixel_req_t req;
        int         gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        req.pad         = '0;
        req.table_entry = entry;
        req.table_index = tidx[9:0];
        req.row         = row[9:0];
        req.column      = col[9:0];
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= req;
        // ready is settled by the falling edge, the transfer happens on the next rising one
        @(negedge aclk);
        while (!s_tready)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic render(input int col, input int row);
        push_item(ACT_RENDER, col, row, $urandom_range(0, 1023), $urandom);
    endtask

    // items go in order, so an entry marked here is stored before any later render reads it
    task automatic table_write(input int tidx, input logic [31:0] entry);
        written[tidx] = 1'b1;
        push_item(ACT_TABLE_WRITE, $urandom_range(0, 1023), $urandom_range(0, 1023), tidx, entry);
    endtask

    // table word with the alpha byte pushed to its extremes now and then
    function automatic logic [31:0] random_entry();
        logic [31:0] e;
        e = $urandom;
        case ($urandom_range(0, 3))
            0: e[7:0] = 8'h00;
            1: e[7:0] = 8'hff;
            default: ;
        endcase
        return e;
    endfunction

    // table entry that a render at this column reads in map mode
    function automatic int map_index(input int col);
        int     span, x;
        longint step, idx;
        span = reg_value[CFG_GRADIENT_WIDTH];
        if (span == 0)
            span = 1;
        if (span > GCAB_MAX_COLUMNS)
            span = GCAB_MAX_COLUMNS;
        x = (col < span) ? col : span - 1;
        step = (longint'(GCAB_TABLE_DEPTH) << 16) / span;
        idx = (x * step) >> 16;
        if (idx >= GCAB_TABLE_DEPTH)
            idx = GCAB_TABLE_DEPTH - 1;
        return int'(idx);
    endfunction

    // mostly inside the span, some at or past its end; in map mode only columns whose
    // entry is written, column 0 always reads entry 0
    function automatic int pick_column();
        int span, col;
        span = reg_value[CFG_GRADIENT_WIDTH];
        if (span == 0)
            span = 1;
        if (span > GCAB_MAX_COLUMNS)
            span = GCAB_MAX_COLUMNS;
        for (int tries = 0; tries < 16; tries++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: col = $urandom_range(0, span - 1);
                5, 6:          col = $urandom_range(span - 1, 1023);
                default:       col = $urandom_range(0, 1023);
            endcase
            if (reg_value[CFG_USE_MAP] == 0 || written[map_index(col)])
                return col;
        end
        return 0;
    endfunction

    task automatic random_item();
        if ($urandom_range(0, 99) < 85)
            render(pick_column(), $urandom_range(0, 1023));
        else
            table_write($urandom_range(0, 1023), random_entry());
    endtask

    // wait until every pixel has come out, then let table writes drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // writes all registers in back-to-back cycles, block must be idle
    task automatic load_config();
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= cfg_reg_t'(i);
            cfg_wr_data <= reg_value[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic default_config();
        reg_value[CFG_START_COLOR]    = START_COLOR_RST;
        reg_value[CFG_END_COLOR]      = END_COLOR_RST;
        reg_value[CFG_DARK_LEVEL]     = DARK_LEVEL_RST;
        reg_value[CFG_LIGHT_LEVEL]    = LIGHT_LEVEL_RST;
        reg_value[CFG_CHECK_MASK]     = CHECK_MASK_RST;
        reg_value[CFG_GRADIENT_WIDTH] = GRADIENT_WIDTH_RST;
        reg_value[CFG_USE_MAP]        = 0;
    endtask

    // first phases pin the extremes, the rest are random
    task automatic phase_config(input int phase);
        reg_value[CFG_START_COLOR] = $urandom;
        reg_value[CFG_END_COLOR]   = $urandom;
        if ($urandom_range(0, 1))
            reg_value[CFG_END_COLOR][7:0] = 8'hff;
        reg_value[CFG_DARK_LEVEL]  = $urandom_range(0, 255);
        reg_value[CFG_LIGHT_LEVEL] = $urandom_range(0, 255);
        case ($urandom_range(0, 2))
            0:       reg_value[CFG_CHECK_MASK] = $urandom_range(0, 1023);
            1:       reg_value[CFG_CHECK_MASK] = 1 << $urandom_range(0, 9);
            default: reg_value[CFG_CHECK_MASK] = 0;
        endcase
        // narrow spans (1 to 32) in half of the draws
        case ($urandom_range(0, 3))
            0, 1:    reg_value[CFG_GRADIENT_WIDTH] = $urandom_range(1, 32);
            2:       reg_value[CFG_GRADIENT_WIDTH] = $urandom_range(1, 1024);
            default: reg_value[CFG_GRADIENT_WIDTH] = $urandom_range(0, 2047);
        endcase
        reg_value[CFG_USE_MAP] = $urandom_range(0, 1);
        case (phase)
            0: begin
                reg_value[CFG_START_COLOR]    = 32'h0000_0000;
                reg_value[CFG_END_COLOR]      = 32'hffff_ffff;
                reg_value[CFG_DARK_LEVEL]     = 8'h00;
                reg_value[CFG_LIGHT_LEVEL]    = 8'hff;
                reg_value[CFG_CHECK_MASK]     = 0;
                reg_value[CFG_GRADIENT_WIDTH] = 1;
                reg_value[CFG_USE_MAP]        = 0;
            end
            1: begin
                reg_value[CFG_START_COLOR]    = 32'hffff_ffff;
                reg_value[CFG_END_COLOR]      = 32'h0000_0000;
                reg_value[CFG_DARK_LEVEL]     = 8'hff;
                reg_value[CFG_LIGHT_LEVEL]    = 8'h00;
                reg_value[CFG_CHECK_MASK]     = 10'h3ff;
                reg_value[CFG_GRADIENT_WIDTH] = 1024;
                reg_value[CFG_USE_MAP]        = 1;
            end
            // zero width acts as one column
            2: reg_value[CFG_GRADIENT_WIDTH] = 0;
            // widths at and past the column limit; past it they saturate
            3: reg_value[CFG_GRADIENT_WIDTH] = 2047;
            4: reg_value[CFG_GRADIENT_WIDTH] = 1025;
            5: reg_value[CFG_GRADIENT_WIDTH] = 1024;
            default: ;
        endcase
    endtask

    // result side: random stalls with calm stretches
    initial begin
        int stall;
        int served;
        served = 0;
        forever begin
            stall = receiver_quiet ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(negedge aclk);
            while (!m_tvalid)
                @(negedge aclk);
            @(posedge aclk);
            served++;
            if (served % 40 == 0)
                receiver_quiet = ($urandom_range(0, 2) == 0);
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        default_config();

        // directed: reset settings, corners of the coordinates, clamp past the width, checker squares, table writes
        render(0, 0);
        render(1023, 1023);
        render(95, 0);
        render(96, 0);
        render(1023, 0);
        render(8, 0);
        render(8, 8);
        render(0, 8);
        table_write(0, 32'hffff_ffff);
        table_write(1023, 32'h0000_0000);
        table_write(512, 32'h8040_20c0);

        // a spread of table entries; map-mode renders only read written ones
        sender_quiet = 1'b1;
        for (int i = 0; i < FILL_ITEMS; i++)
            table_write($urandom_range(0, GCAB_TABLE_DEPTH - 1), random_entry());
        sender_quiet = 1'b0;

        // directed: map mode over the full column range
        settle();
        reg_value[CFG_GRADIENT_WIDTH] = 1024;
        reg_value[CFG_USE_MAP]        = 1;
        load_config();
        render(0, 0);
        render(1023, 1023);
        render(512, 3);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            phase_config(p);
            load_config();
            sender_quiet = (p % 4 == 3);
            repeat (PHASE_ITEMS) random_item();
        end

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/gcab_pkg.sv
rtl/core/gradient_checker_alpha_blend.sv
tb/gcab_tb_pkg.sv
tb/pixel_checker.sv
tb/tb.sv
